// File: rtl/adsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package adsu_pkg;

  localparam int PHI_W  = 16;
  localparam int VEL_W  = 16;
  localparam int COEF_W = 16;
  localparam int CX_W   = 10;
  localparam int CY_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_HEIGHT = 4096;
  localparam int FIN_W  = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP       = 3'd6;

  // saturate to Q2.13 range, then optional clamp to [0, 1.0]
  function automatic logic signed [PHI_W-1:0] finish_phi(
      input logic signed [FIN_W-1:0] val, input logic clamp);
    logic signed [FIN_W-1:0] v;
    v = val;
    if (v > 40'sd32767) v = 40'sd32767;
    if (v < -40'sd32768) v = -40'sd32768;
    if (clamp) begin
      if (v < 40'sd0) v = 40'sd0;
      if (v > 40'sd8192) v = 40'sd8192;
    end
    return v[PHI_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/adsu_cell_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface adsu_cell_if import adsu_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [PHI_W-1:0] phi_old;
  logic signed [VEL_W-1:0] u_vel;
  logic signed [VEL_W-1:0] v_vel;
  modport source (output valid, phi_old, u_vel, v_vel, input ready);
  modport sink   (input valid, phi_old, u_vel, v_vel, output ready);
endinterface
`default_nettype wire

// File: rtl/adsu_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface adsu_result_if import adsu_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [CX_W-1:0]         cell_x;
  logic [CY_W-1:0]         cell_y;
  logic signed [PHI_W-1:0] phi_new;
  logic                    last_of_run;
  modport source (output valid, cell_x, cell_y, phi_new, last_of_run, input ready);
  modport sink   (input valid, cell_x, cell_y, phi_new, last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/advection_diffusion_stencil_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a boundary-only cell's result is registered in S_RB; an interior result in
//   S_M3 after S_RC, S_RD and S_M2, and a trailing boundary result once that one is taken.
// Flow: one cell in flight, accepted only in S_IDLE; output stalls hold the block;
//   pace set by the two serial reads of the single line-buffer RAM and the multiply chain.
// Reset (rst_n, synchronous, active low) clears counters, centre velocities, control
//   and coefficients, sets full size; line-buffer RAM, window undefined until written.
module advection_diffusion_stencil_unit import adsu_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  adsu_cell_if.sink                  in_cell,
  adsu_result_if.source              out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int MW = 2 * PHI_W + 2 * VEL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_RD, S_M2, S_M3, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [10:0]       grid_width_r;
  logic [12:0]       grid_height_r;
  logic [COEF_W-1:0] adv_x_r, adv_y_r, diff_x_r, diff_y_r;
  logic              clamp_r;

  // line buffer: {two_above, above, u_above, v_above}
  logic [MW-1:0] mem [MAX_WIDTH];
  logic [MW-1:0] rdata_r;
  logic [XW-1:0] addr_r;

  logic [XW-1:0]   col_r;
  logic [CY_W-1:0] row_r;
  logic [XW-1:0]   x_r;
  logic [CY_W-1:0] y_r;
  logic            bnd_r, intr_r, pend_r;
  logic signed [PHI_W-1:0] p_r, w_r [6];
  logic signed [VEL_W-1:0] u_r, v_r, cu_r, cv_r, cu_use_r, cv_use_r;

  // arithmetic pipeline
  logic signed [32:0] pu_r, pv_r;
  logic signed [35:0] qx_r, qy_r;
  logic signed [16:0] rl_r, bt_r;
  logic signed [PHI_W-1:0] c_r;
  logic signed [49:0] au_r, av_r;
  logic signed [PHI_W-1:0] c2_r;
  logic signed [36:0] dq_r;

  // output register
  logic                    ovalid_r, olast_r;
  logic [CX_W-1:0]         ox_r;
  logic [CY_W-1:0]         oy_r;
  logic signed [PHI_W-1:0] ophi_r;

  // effective sizes and current position
  logic [31:0] w32, h32, x32, y32;
  always_comb begin
    w32 = 32'(grid_width_r);
    if (w32 < 32'd3) w32 = 32'd3;
    if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    h32 = 32'(grid_height_r);
    if (h32 < 32'd3) h32 = 32'd3;
    if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    x32 = (32'(col_r) < w32) ? 32'(col_r) : w32 - 32'd1;
    y32 = (32'(row_r) < h32) ? 32'(row_r) : h32 - 32'd1;
  end

  logic in_fire, out_fire;
  assign in_cell.ready = (state_r == S_IDLE);
  assign in_fire  = in_cell.valid && in_cell.ready;
  assign out_fire = ovalid_r && out_res.ready;

  assign out_res.valid       = ovalid_r;
  assign out_res.cell_x      = ox_r;
  assign out_res.cell_y      = oy_r;
  assign out_res.phi_new     = ophi_r;
  assign out_res.last_of_run = olast_r;

  // field views of the RAM word
  logic signed [PHI_W-1:0] rd_two, rd_above;
  logic signed [VEL_W-1:0] rd_u, rd_v;
  assign rd_two   = rdata_r[MW-1 -: PHI_W];
  assign rd_above = rdata_r[MW-PHI_W-1 -: PHI_W];
  assign rd_u     = rdata_r[2*VEL_W-1 -: VEL_W];
  assign rd_v     = rdata_r[VEL_W-1:0];

  logic mem_we;
  assign mem_we = (state_r == S_RB);

  always_ff @(posedge clk) begin
    if (mem_we) mem[x_r] <= {rd_above, p_r, u_r, v_r};
    rdata_r <= mem[addr_r];
  end

  // second stage sums
  logic signed [51:0] adv_sum, tot;
  logic signed [33:0] delta;
  logic signed [FIN_W-1:0] pre;
  always_comb begin
    adv_sum = 52'(au_r) + 52'(av_r);
    tot     = (52'(dq_r) <<< 7) - adv_sum;
    delta   = 34'((tot + 52'sd262144) >>> 19);
    pre     = FIN_W'(c2_r) + FIN_W'(delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      grid_width_r  <= 11'd1024;
      grid_height_r <= 13'd4096;
      adv_x_r  <= '0;
      adv_y_r  <= '0;
      diff_x_r <= '0;
      diff_y_r <= '0;
      clamp_r  <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      cu_r     <= '0;
      cv_r     <= '0;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_width_r  <= cfg_data[10:0];
          CFG_GRID_HEIGHT: grid_height_r <= cfg_data[12:0];
          CFG_ADV_X:       adv_x_r  <= cfg_data;
          CFG_ADV_Y:       adv_y_r  <= cfg_data;
          CFG_DIFF_X:      diff_x_r <= cfg_data;
          CFG_DIFF_Y:      diff_y_r <= cfg_data;
          CFG_CLAMP:       clamp_r  <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            p_r    <= in_cell.phi_old;
            u_r    <= in_cell.u_vel;
            v_r    <= in_cell.v_vel;
            x_r    <= XW'(x32);
            y_r    <= CY_W'(y32);
            addr_r <= XW'(x32);
            intr_r <= (x32 >= 32'd2) && (y32 >= 32'd2);
            bnd_r  <= (y32 == 32'd0) || (y32 == h32 - 32'd1) ||
                      (x32 == 32'd0) || (x32 == w32 - 32'd1);
            if (x32 + 32'd1 >= w32) begin
              col_r <= '0;
              row_r <= (y32 + 32'd1 >= h32) ? '0 : CY_W'(y32 + 32'd1);
            end else begin
              col_r <= XW'(x32 + 32'd1);
              row_r <= CY_W'(y32);
            end
            state_r <= S_RA;
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          // slide window, capture centre velocities of (x, y-1)
          w_r[0] <= w_r[1];
          w_r[1] <= w_r[2];
          w_r[2] <= rd_two;
          w_r[3] <= w_r[4];
          w_r[4] <= w_r[5];
          w_r[5] <= rd_above;
          cu_use_r <= cu_r;
          cv_use_r <= cv_r;
          cu_r <= rd_u;
          cv_r <= rd_v;
          addr_r <= x_r - XW'(1);
          if (intr_r) begin
            state_r <= S_RC;
          end else if (bnd_r) begin
            ovalid_r <= 1'b1;
            olast_r  <= 1'b1;
            ox_r     <= CX_W'(x_r);
            oy_r     <= y_r;
            ophi_r   <= finish_phi(FIN_W'(p_r), clamp_r);
            state_r  <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_RC: state_r <= S_RD;
        S_RD: begin
          // rdata now holds entry x-1; its above field is the bottom neighbour
          pu_r <= cu_use_r * $signed({1'b0, adv_x_r});
          pv_r <= cv_use_r * $signed({1'b0, adv_y_r});
          qx_r <= $signed({1'b0, diff_x_r}) *
                  (19'(w_r[5]) - (19'(w_r[4]) <<< 1) + 19'(w_r[3]));
          qy_r <= $signed({1'b0, diff_y_r}) *
                  (19'(rd_above) - (19'(w_r[4]) <<< 1) + 19'(w_r[1]));
          rl_r <= 17'(w_r[5]) - 17'(w_r[3]);
          bt_r <= 17'(rd_above) - 17'(w_r[1]);
          c_r  <= w_r[4];
          state_r <= S_M2;
        end
        S_M2: begin
          au_r <= pu_r * rl_r;
          av_r <= pv_r * bt_r;
          dq_r <= 37'(qx_r) + 37'(qy_r);
          c2_r <= c_r;
          state_r <= S_M3;
        end
        S_M3: begin
          ovalid_r <= 1'b1;
          olast_r  <= !bnd_r;
          pend_r   <= bnd_r;
          ox_r     <= CX_W'(x_r - XW'(1));
          oy_r     <= y_r - CY_W'(1);
          ophi_r   <= finish_phi(pre, clamp_r);
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            if (pend_r) begin
              pend_r  <= 1'b0;
              olast_r <= 1'b1;
              ox_r    <= CX_W'(x_r);
              oy_r    <= y_r;
              ophi_r  <= finish_phi(FIN_W'(p_r), clamp_r);
            end else begin
              ovalid_r <= 1'b0;
              state_r  <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result is only presented from the output state
  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (state_r == S_OUT)) else $error("result valid outside output state");
  // no new cell while a result is waiting
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_cell.ready |-> !ovalid_r) else $error("input ready with pending result");
  // a pending boundary result is never flagged last on the interior result
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && pend_r) |-> !olast_r) else $error("last flag with pending result");
  // the line buffer is written once per cell, right after the first read
  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> $past(state_r == S_RA)) else $error("line buffer write out of sequence");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import adsu_pkg::*;

  // Register index with no register behind it; a write there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;
  localparam int  HALF_PERIOD = 6;
  localparam int  DRAIN_CYCLES = 24;     // settle margin after the last owed result
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int  REPORT_MAX = 10;

  typedef struct packed {
    logic [CX_W-1:0]         cell_x;
    logic [CY_W-1:0]         cell_y;
    logic signed [PHI_W-1:0] phi_new;
    logic                    last_of_run;
  } cell_result_t;

  // Stencil predictor plus queue of results still owed by the block
  class stencil_scoreboard;
    logic signed [PHI_W-1:0] phi_above [1024];
    logic signed [PHI_W-1:0] phi_two_above [1024];
    logic signed [VEL_W-1:0] u_above [1024];
    logic signed [VEL_W-1:0] v_above [1024];
    logic signed [PHI_W-1:0] win [6];
    logic signed [VEL_W-1:0] cen_u, cen_v;
    int unsigned col, row;
    bit [10:0] width_reg;
    bit [12:0] height_reg;
    bit [15:0] ax, ay, dfx, dfy;
    bit        clamp;
    cell_result_t owed_q[$];
    int errors;

    function new();
      width_reg = 11'd1024;
      height_reg = 13'd4096;
      ax = 0; ay = 0; dfx = 0; dfy = 0; clamp = 0;
      cen_u = 0; cen_v = 0; col = 0; row = 0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_GRID_WIDTH:  width_reg = d[10:0];
        CFG_GRID_HEIGHT: height_reg = d[12:0];
        CFG_ADV_X:       ax = d;
        CFG_ADV_Y:       ay = d;
        CFG_DIFF_X:      dfx = d;
        CFG_DIFF_Y:      dfy = d;
        CFG_CLAMP:       clamp = d[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      eff_width = width_reg < 3 ? 3 : (width_reg > 1024 ? 1024 : width_reg);
    endfunction

    function int unsigned eff_height();
      eff_height = height_reg < 3 ? 3 : (height_reg > 4096 ? 4096 : height_reg);
    endfunction

    function logic signed [PHI_W-1:0] limit_phi(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      if (clamp) begin
        if (v < 0) v = 0;
        if (v > 8192) v = 8192;
      end
      limit_phi = v[PHI_W-1:0];
    endfunction

    function void note_cell(logic signed [PHI_W-1:0] p, logic signed [VEL_W-1:0] u,
                            logic signed [VEL_W-1:0] v);
      int unsigned w, h, x, y;
      longint t, l, c, r, b, adv, dif, delta;
      cell_result_t e;
      int n;
      n = 0;
      w = eff_width();
      h = eff_height();
      x = col < w ? col : w - 1;
      y = row < h ? row : h - 1;
      win[0] = win[1]; win[1] = win[2]; win[2] = phi_two_above[x];
      win[3] = win[4]; win[4] = win[5]; win[5] = phi_above[x];
      if (x >= 2 && y >= 2) begin
        t = win[1]; l = win[3]; c = win[4]; r = win[5];
        b = phi_above[x-1];
        adv = longint'(cen_u) * longint'(ax) * (r - l)
            + longint'(cen_v) * longint'(ay) * (b - t);
        dif = (longint'(dfx) * (r - 2*c + l) + longint'(dfy) * (b - 2*c + t)) * 128;
        // round half up from Q.32 to Q.13
        delta = (dif - adv + 64'sd262144) >>> 19;
        e.cell_x = CX_W'(x - 1);
        e.cell_y = CY_W'(y - 1);
        e.phi_new = limit_phi(c + delta);
        e.last_of_run = 1'b0;
        owed_q.push_back(e);
        n++;
      end
      cen_u = u_above[x];
      cen_v = v_above[x];
      phi_two_above[x] = phi_above[x];
      phi_above[x] = p;
      u_above[x] = u;
      v_above[x] = v;
      if (y == 0 || y == h - 1 || x == 0 || x == w - 1) begin
        e.cell_x = CX_W'(x);
        e.cell_y = CY_W'(y);
        e.phi_new = limit_phi(p);
        e.last_of_run = 1'b0;
        owed_q.push_back(e);
        n++;
      end
      if (n > 0) owed_q[owed_q.size()-1].last_of_run = 1'b1;
      if (x + 1 >= w) begin
        col = 0;
        row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col = x + 1;
        row = y;
      end
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t e;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result x=%0d y=%0d phi=%0d", got.cell_x, got.cell_y,
                   got.phi_new);
        return;
      end
      e = owed_q.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("mismatch: exp x=%0d y=%0d phi=%0d last=%0d, got x=%0d y=%0d phi=%0d last=%0d",
                   e.cell_x, e.cell_y, e.phi_new, e.last_of_run,
                   got.cell_x, got.cell_y, got.phi_new, got.last_of_run);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adsu_cell_if   cell_bus ();
  adsu_result_if res_bus ();

  advection_diffusion_stencil_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cell   (cell_bus.sink),
    .out_res   (res_bus.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stencil_scoreboard sb = new();

  int     idle_pct = 0;     // sender gap probability, percent
  int     stall_pct = 0;    // receiver stall probability, percent
  int     hold_left = 0;    // long receiver hold-off, cycles still to run
  longint cycles = 0;

  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    cell_bus.valid   = 1'b0;
    cell_bus.phi_old = '0;
    cell_bus.u_vel   = '0;
    cell_bus.v_vel   = '0;
    res_bus.ready    = 1'b0;
  end

  // Receiver: random stalls, and a counted hold-off when one is armed
  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result monitor; a transaction is taken on valid && ready at the edge
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready)
      sb.check_result({res_bus.cell_x, res_bus.cell_y, res_bus.phi_new, res_bus.last_of_run});
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Offer one cell and return at the edge that takes the transaction
  task automatic send_cell(logic signed [PHI_W-1:0] p, logic signed [VEL_W-1:0] u,
                           logic signed [VEL_W-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 6) gap++;
    if (gap > 0) begin
      cell_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_bus.valid   <= 1'b1;
    cell_bus.phi_old <= p;
    cell_bus.u_vel   <= u;
    cell_bus.v_vel   <= v;
    do @(posedge clk); while (!cell_bus.ready);
    sb.note_cell(p, u, v);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: pick_word = 16'h8000;
      1: pick_word = 16'h7fff;
      2: pick_word = 16'h0000;
      3: pick_word = 16'h2000;
      default: pick_word = 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(4))
      0: pick_coef = 16'h0000;
      1: pick_coef = 16'hffff;
      2: pick_coef = 16'($urandom_range(2047));
      default: pick_coef = 16'($urandom);
    endcase
  endfunction

  task automatic send_random_cell();
    send_cell(pick_word(), pick_word(), pick_word());
  endtask

  // Send cells until the frame counters wrap back to the origin
  task automatic send_frame();
    do send_random_cell(); while (sb.col != 0 || sb.row != 0);
  endtask

  // Stop offering, wait for every owed result, then let the pipe settle
  task automatic drain();
    @(posedge clk);
    cell_bus.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_coefs();
    write_cfg(CFG_ADV_X, pick_coef());
    write_cfg(CFG_ADV_Y, pick_coef());
    write_cfg(CFG_DIFF_X, pick_coef());
    write_cfg(CFG_DIFF_Y, pick_coef());
    write_cfg(CFG_CLAMP, CFG_DATA_W'($urandom_range(1)));
  endtask

  task automatic set_size(int w, int h);
    write_cfg(CFG_GRID_WIDTH, CFG_DATA_W'(w));
    write_cfg(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
  endtask

  initial begin
    int sent_in_phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 frame at full-scale coefficients, then 4x4 with clamping, field extremes
    set_size(3, 3);
    write_cfg(CFG_ADV_X, 16'hffff);
    write_cfg(CFG_ADV_Y, 16'hffff);
    write_cfg(CFG_DIFF_X, 16'hffff);
    write_cfg(CFG_DIFF_Y, 16'hffff);
    write_cfg(CFG_CLAMP, 16'd0);
    write_cfg(CFG_NONE, 16'hffff);
    send_cell(16'sh7fff, 16'sh7fff, 16'sh8000);
    send_cell(16'sh8000, 16'sh8000, 16'sh7fff);
    send_cell(16'sh0000, 16'sh0000, 16'sh0000);
    send_cell(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_cell(16'sh7fff, 16'sh8000, 16'sh8000);   // lone interior cell
    send_cell(16'sh8000, 16'sh0001, 16'shffff);
    send_cell(16'sh2000, 16'sh0080, 16'sh0080);
    send_cell(16'sh7fff, 16'shff80, 16'sh0000);
    send_cell(16'shffff, 16'sh0000, 16'sh0080);
    drain();
    write_cfg(CFG_CLAMP, 16'd1);
    write_cfg(CFG_DIFF_X, 16'h0400);
    write_cfg(CFG_ADV_Y, 16'h0000);
    set_size(4, 4);
    for (int k = 0; k < 16; k++)
      send_cell(k[0] ? 16'sh7fff : 16'sh8000, k[1] ? 16'sh7fff : 16'sh8000,
                k[2] ? 16'sh7fff : 16'sh8000);
    drain();

    // Random phases; idling style rotates through the four settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      random_coefs();
      sent_in_phase = 0;
      if (ph == 1) begin
        // Long receiver hold-off while cells keep coming: block must back up
        set_size(8, 6);
        @(posedge clk);
        hold_left <= 400;
      end
      if (ph == 5) begin
        // Height shrunk mid-frame: current row becomes the last one
        set_size(5, 7);
        while (sb.row < 4) send_random_cell();
        drain();
        write_cfg(CFG_GRID_HEIGHT, 16'd3);
        send_frame();
        drain();
      end
      if (ph == 6) begin
        set_size(2047, 3);    // width out of range, taken as the maximum
        while (sb.row < 1) send_random_cell();
        drain();
        // Narrower width from the second row on; its columns were all written in row 0
        write_cfg(CFG_GRID_WIDTH, 16'd3);
        send_frame();
        drain();
      end
      if (ph == 7) begin
        set_size(0, 8191);    // both out of range: 3 wide, full height
        while (sb.row < 3) send_random_cell();
        drain();
        // Height zero taken as 3: the current row becomes the last one
        write_cfg(CFG_GRID_HEIGHT, 16'd0);
        send_frame();
        drain();
      end
      while (sent_in_phase < 60) begin
        if ($urandom_range(3) == 0) set_size($urandom_range(3, 24), $urandom_range(3, 8));
        else set_size($urandom_range(3, 9), $urandom_range(3, 5));
        sent_in_phase += sb.eff_width() * sb.eff_height();
        send_frame();
        drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
